// File: hdl/tsn_pkg.sv
// Shared types and constants for the telnet stream negotiator.
// Used by the parser, option table, emitter and top level; no dependencies.
package tsn_pkg;

    // Default sizes handed to the top-level parameters
    localparam int OPTION_COUNT_DEF = 256;
    localparam int TERM_MAX_DEF     = 8;

    // Telnet command bytes
    localparam logic [7:0] B_SE   = 8'd240;
    localparam logic [7:0] B_SB   = 8'd250;
    localparam logic [7:0] B_WILL = 8'd251;
    localparam logic [7:0] B_WONT = 8'd252;
    localparam logic [7:0] B_DO   = 8'd253;
    localparam logic [7:0] B_DONT = 8'd254;
    localparam logic [7:0] B_IAC  = 8'd255;

    // Option numbers with special handling
    localparam logic [7:0] OPT_ECHO  = 8'd1;
    localparam logic [7:0] OPT_TTYPE = 8'd24;

    // Per-direction option states
    localparam logic [1:0] ST_CANT = 2'd0;
    localparam logic [1:0] ST_NO   = 2'd1;
    localparam logic [1:0] ST_YES  = 2'd2;

    // Configuration register indexes
    localparam logic [0:0] REG_TERM_TEXT   = 1'b0;
    localparam logic [0:0] REG_TERM_LENGTH = 1'b1;

    // Reset values of the configuration registers ("UNKNOWN", 7 characters)
    localparam logic [63:0] TERM_TEXT_RST   = 64'd22051046311022165;
    localparam logic [3:0]  TERM_LENGTH_RST = 4'd7;

    // Kinds of output job handed from the parser to the emitter
    typedef enum logic [1:0] {
        JOB_LOCAL = 2'd0,   // user byte to network, IAC doubled
        JOB_PASS  = 2'd1,   // network byte to local user
        JOB_OPT   = 2'd2,   // option command, reply decided from the table
        JOB_TTYPE = 2'd3    // terminal type answer
    } job_kind_t;

    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] data;   // byte for LOCAL/PASS, command for OPT
        logic [7:0] opt;    // option number for OPT
    } job_t;

    // Option table read request
    typedef struct packed {
        logic       en;
        logic [7:0] idx;
    } mem_rd_t;

    // Option table write request; entry is {local state, remote state}
    typedef struct packed {
        logic       en;
        logic [7:0] idx;
        logic [3:0] entry;
    } mem_wr_t;

endpackage

// File: hdl/tsn_opt_mem.sv
// Option state table: synchronous memory with registered read.
// Valid bits give the reset contents; a same-edge write is forwarded. Uses tsn_pkg.
module tsn_opt_mem #(
    parameter int OPTION_COUNT = tsn_pkg::OPTION_COUNT_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  tsn_pkg::mem_rd_t rd,
    input  tsn_pkg::mem_wr_t wr,
    output logic [3:0]       rd_data
);

    localparam int AW = (OPTION_COUNT > 1) ? $clog2(OPTION_COUNT) : 1;

    logic [3:0]              mem [OPTION_COUNT];
    logic [OPTION_COUNT-1:0] vld_reg;
    logic [3:0]              rd_data_reg;

    logic          rd_rng;
    logic          wr_rng;
    logic [AW-1:0] ra;
    logic [AW-1:0] wa;
    logic [3:0]    rst_entry;

    // Options beyond the table read as cant and are never stored
    assign rd_rng = {1'b0, rd.idx} < 9'(OPTION_COUNT);
    assign wr_rng = {1'b0, wr.idx} < 9'(OPTION_COUNT);
    assign ra     = rd.idx[AW-1:0];
    assign wa     = wr.idx[AW-1:0];

    // Contents of an entry never written since reset
    always_comb begin
        rst_entry = {tsn_pkg::ST_CANT, tsn_pkg::ST_CANT};
        if (rd.idx == tsn_pkg::OPT_ECHO) begin
            rst_entry = {tsn_pkg::ST_CANT, tsn_pkg::ST_NO};
        end else if (rd.idx == tsn_pkg::OPT_TTYPE) begin
            rst_entry = {tsn_pkg::ST_NO, tsn_pkg::ST_CANT};
        end
    end

    // Write port
    always_ff @(posedge aclk) begin
        if (wr.en && wr_rng) begin
            mem[wa] <= wr.entry;
        end
    end

    // Mark written entries; reset returns the whole table to its defaults
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr.en && wr_rng) begin
            vld_reg[wa] <= 1'b1;
        end
    end

    // Read port, forward a write to the same entry at the same edge
    always_ff @(posedge aclk) begin
        if (rd.en) begin
            if (!rd_rng) begin
                rd_data_reg <= {tsn_pkg::ST_CANT, tsn_pkg::ST_CANT};
            end else if (wr.en && wr.idx == rd.idx) begin
                rd_data_reg <= wr.entry;
            end else if (vld_reg[ra]) begin
                rd_data_reg <= mem[ra];
            end else begin
                rd_data_reg <= rst_entry;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/tsn_parse.sv
// Receive-side command parser: five-phase state machine that turns accepted beats
// into output jobs and option table reads. Uses tsn_pkg.
module tsn_parse (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic              mode,
    input  logic [7:0]        byte_in,
    output logic              job_vld,
    output tsn_pkg::job_t     job,
    output tsn_pkg::mem_rd_t  rd
);

    typedef enum logic [4:0] {
        PH_DATA    = 5'b00001,
        PH_CODE    = 5'b00010,
        PH_OPTION  = 5'b00100,
        PH_SUBPAR  = 5'b01000,
        PH_SUBCODE = 5'b10000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] pend_reg, pend_next;
    logic [7:0] subopt_reg, subopt_next;

    logic is_neg_cmd;
    logic pend_is_neg;

    assign is_neg_cmd  = (byte_in == tsn_pkg::B_WILL) || (byte_in == tsn_pkg::B_WONT) ||
                         (byte_in == tsn_pkg::B_DO)   || (byte_in == tsn_pkg::B_DONT);
    assign pend_is_neg = (pend_reg == tsn_pkg::B_WILL) || (pend_reg == tsn_pkg::B_WONT) ||
                         (pend_reg == tsn_pkg::B_DO)   || (pend_reg == tsn_pkg::B_DONT);

    // Decode one beat
    always_comb begin
        phase_next  = phase_reg;
        pend_next   = pend_reg;
        subopt_next = subopt_reg;
        job_vld     = 1'b0;
        job.kind    = tsn_pkg::JOB_PASS;
        job.data    = byte_in;
        job.opt     = byte_in;
        rd.en       = 1'b0;
        rd.idx      = byte_in;
        if (accept) begin
            if (mode) begin
                job_vld  = 1'b1;
                job.kind = tsn_pkg::JOB_LOCAL;
            end else begin
                unique case (phase_reg)
                    PH_CODE: begin
                        if (byte_in == tsn_pkg::B_IAC) begin
                            job_vld    = 1'b1;
                            phase_next = PH_DATA;
                        end else if (byte_in == tsn_pkg::B_SB || is_neg_cmd) begin
                            pend_next  = byte_in;
                            phase_next = PH_OPTION;
                        end else begin
                            phase_next = PH_DATA;
                        end
                    end
                    PH_OPTION: begin
                        if (pend_reg == tsn_pkg::B_SB) begin
                            subopt_next = byte_in;
                            phase_next  = PH_SUBPAR;
                        end else begin
                            phase_next = PH_DATA;
                            if (pend_is_neg) begin
                                job_vld  = 1'b1;
                                job.kind = tsn_pkg::JOB_OPT;
                                job.data = pend_reg;
                                rd.en    = 1'b1;
                            end
                        end
                    end
                    PH_SUBPAR: begin
                        if (byte_in == tsn_pkg::B_IAC) begin
                            phase_next = PH_SUBCODE;
                        end
                    end
                    PH_SUBCODE: begin
                        if (byte_in == tsn_pkg::B_IAC) begin
                            phase_next = PH_SUBPAR;
                        end else begin
                            phase_next = PH_DATA;
                            if (byte_in == tsn_pkg::B_SE && subopt_reg == tsn_pkg::OPT_TTYPE) begin
                                job_vld  = 1'b1;
                                job.kind = tsn_pkg::JOB_TTYPE;
                            end
                        end
                    end
                    default: begin
                        if (byte_in == tsn_pkg::B_IAC) begin
                            phase_next = PH_CODE;
                        end else begin
                            job_vld    = 1'b1;
                            phase_next = PH_DATA;
                        end
                    end
                endcase
            end
        end
    end

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_DATA;
            pend_reg   <= '0;
            subopt_reg <= '0;
        end else begin
            phase_reg  <= phase_next;
            pend_reg   <= pend_next;
            subopt_reg <= subopt_next;
        end
    end

endmodule

// File: hdl/tsn_emit.sv
// Output sequencer: holds one job, resolves option replies against the table,
// writes the table back and drives the registered result channel. Uses tsn_pkg.
module tsn_emit #(
    parameter int TERM_MAX = tsn_pkg::TERM_MAX_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  tsn_pkg::job_t     job_in,
    output logic              ready,
    input  logic [3:0]        tbl_data,
    output tsn_pkg::mem_wr_t  wr,
    input  logic [63:0]       term_text,
    input  logic [3:0]        term_length,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic [0:0]        m_tuser,
    output logic              m_tlast
);

    localparam logic [3:0] TERM_MAX_W = 4'(TERM_MAX);

    tsn_pkg::job_t job_reg;
    logic          job_vld_reg, job_vld_next;
    logic [3:0]    idx_reg, idx_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [7:0]    m_tdata_reg;
    logic          m_tuser_reg;
    logic          m_tlast_reg;

    logic       reply;
    logic [7:0] reply_cmd;
    logic       tbl_wr;
    logic [3:0] tbl_entry;
    logic [3:0] len;
    logic [3:0] cnt;
    logic [3:0] txt_sel;
    logic       slot_free;
    logic       emit;
    logic       is_last;
    logic       done;
    logic [7:0] out_byte;
    logic [1:0] remote;
    logic [1:0] local_st;

    assign remote   = tbl_data[1:0];
    assign local_st = tbl_data[3:2];

    // Decide the reply and table update for an option command
    always_comb begin
        reply     = 1'b0;
        reply_cmd = tsn_pkg::B_DONT;
        tbl_wr    = 1'b0;
        tbl_entry = tbl_data;
        unique case (job_reg.data)
            tsn_pkg::B_WILL: begin
                if (remote == tsn_pkg::ST_CANT) begin
                    reply     = 1'b1;
                    reply_cmd = tsn_pkg::B_DONT;
                end else if (remote == tsn_pkg::ST_NO) begin
                    reply     = 1'b1;
                    reply_cmd = tsn_pkg::B_DO;
                    tbl_wr    = 1'b1;
                    tbl_entry = {local_st, tsn_pkg::ST_YES};
                end
            end
            tsn_pkg::B_WONT: begin
                if (remote[1]) begin
                    reply     = 1'b1;
                    reply_cmd = tsn_pkg::B_DONT;
                    tbl_wr    = 1'b1;
                    tbl_entry = {local_st, tsn_pkg::ST_NO};
                end
            end
            tsn_pkg::B_DO: begin
                if (local_st == tsn_pkg::ST_CANT) begin
                    reply     = 1'b1;
                    reply_cmd = tsn_pkg::B_WONT;
                end else if (local_st == tsn_pkg::ST_NO) begin
                    reply     = 1'b1;
                    reply_cmd = tsn_pkg::B_WILL;
                    tbl_wr    = 1'b1;
                    tbl_entry = {tsn_pkg::ST_YES, remote};
                end
            end
            tsn_pkg::B_DONT: begin
                if (local_st[1]) begin
                    reply     = 1'b1;
                    reply_cmd = tsn_pkg::B_WONT;
                    tbl_wr    = 1'b1;
                    tbl_entry = {tsn_pkg::ST_NO, remote};
                end
            end
            default: begin
                reply = 1'b0;
            end
        endcase
    end

    // Terminal text length, saturated
    assign len = (term_length > TERM_MAX_W) ? TERM_MAX_W : term_length;

    // Number of beats for the held job
    always_comb begin
        unique case (job_reg.kind)
            tsn_pkg::JOB_LOCAL: cnt = (job_reg.data == tsn_pkg::B_IAC) ? 4'd2 : 4'd1;
            tsn_pkg::JOB_PASS:  cnt = 4'd1;
            tsn_pkg::JOB_OPT:   cnt = reply ? 4'd3 : 4'd0;
            default:            cnt = 4'd6 + len;
        endcase
    end

    // Byte for the current beat
    assign txt_sel = idx_reg - 4'd4;
    always_comb begin
        out_byte = job_reg.data;
        unique case (job_reg.kind)
            tsn_pkg::JOB_OPT: begin
                if (idx_reg == 4'd0) begin
                    out_byte = tsn_pkg::B_IAC;
                end else if (idx_reg == 4'd1) begin
                    out_byte = reply_cmd;
                end else begin
                    out_byte = job_reg.opt;
                end
            end
            tsn_pkg::JOB_TTYPE: begin
                if (idx_reg == 4'd0) begin
                    out_byte = tsn_pkg::B_IAC;
                end else if (idx_reg == 4'd1) begin
                    out_byte = tsn_pkg::B_SB;
                end else if (idx_reg == 4'd2) begin
                    out_byte = tsn_pkg::OPT_TTYPE;
                end else if (idx_reg == 4'd3) begin
                    out_byte = 8'd0;
                end else if (txt_sel < len) begin
                    out_byte = term_text[{txt_sel[2:0], 3'b000} +: 8];
                end else if (txt_sel == len) begin
                    out_byte = tsn_pkg::B_IAC;
                end else begin
                    out_byte = tsn_pkg::B_SE;
                end
            end
            default: begin
                out_byte = job_reg.data;
            end
        endcase
    end

    // Beat flow control
    assign slot_free = !m_tvalid_reg || m_tready;
    assign emit      = job_vld_reg && (cnt != 4'd0) && slot_free;
    assign is_last   = (idx_reg == cnt - 4'd1);
    assign done      = job_vld_reg && ((cnt == 4'd0) || (slot_free && is_last));
    assign ready     = !job_vld_reg || done;

    // Write the table back once, as the option job retires
    assign wr.en    = done && (job_reg.kind == tsn_pkg::JOB_OPT) && tbl_wr;
    assign wr.idx   = job_reg.opt;
    assign wr.entry = tbl_entry;

    // Advance the job and beat index
    always_comb begin
        job_vld_next = job_vld_reg;
        idx_next     = idx_reg;
        if (load) begin
            job_vld_next = 1'b1;
            idx_next     = 4'd0;
        end else if (done) begin
            job_vld_next = 1'b0;
        end else if (emit) begin
            idx_next = idx_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            job_reg <= job_in;
        end
    end

    // Output register: hold while stalled, drop once taken
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= out_byte;
            m_tuser_reg <= (job_reg.kind != tsn_pkg::JOB_PASS);
            m_tlast_reg <= is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_vld_reg  <= 1'b0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            job_vld_reg  <= job_vld_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;
    assign m_tlast    = m_tlast_reg;

endmodule

// File: hdl/telnet_stream_negotiator.sv
// Telnet stream negotiator. Jobs wait in the job register; result beats go through the
// output register. One input beat per cycle while the job register is free; an item
// with more than one result beat holds the input until its last beat is emitted
// (option replies 3 beats, terminal type answer 6 plus text length). Items with no
// result never hold the input. Reset: synchronous, active low; clears parser, job and
// output state and the option table valid bits, with no clearing pass.
module telnet_stream_negotiator #(
    parameter int OPTION_COUNT = tsn_pkg::OPTION_COUNT_DEF,
    parameter int TERM_MAX     = tsn_pkg::TERM_MAX_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic [0:0]  s_tuser,    // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic [0:0]  m_tuser,    // [0] to_network
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);

    logic             accept;
    logic             job_vld;
    tsn_pkg::job_t    job;
    tsn_pkg::mem_rd_t rd;
    tsn_pkg::mem_wr_t wr;
    logic [3:0]       tbl_data;
    logic             emit_ready;

    logic [63:0] term_text_reg, term_text_next;
    logic [3:0]  term_length_reg, term_length_next;

    assign s_tready = emit_ready;
    assign accept   = s_tvalid && s_tready;

    // Configuration writes
    always_comb begin
        term_text_next   = term_text_reg;
        term_length_next = term_length_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                tsn_pkg::REG_TERM_TEXT:   term_text_next   = cfg_wdata;
                tsn_pkg::REG_TERM_LENGTH: term_length_next = cfg_wdata[3:0];
                default:                  term_text_next   = term_text_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_text_reg   <= tsn_pkg::TERM_TEXT_RST;
            term_length_reg <= tsn_pkg::TERM_LENGTH_RST;
        end else begin
            term_text_reg   <= term_text_next;
            term_length_reg <= term_length_next;
        end
    end

    tsn_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .mode    (s_tuser[0]),
        .byte_in (s_tdata),
        .job_vld (job_vld),
        .job     (job),
        .rd      (rd)
    );

    tsn_opt_mem #(
        .OPTION_COUNT (OPTION_COUNT)
    ) u_opt_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd      (rd),
        .wr      (wr),
        .rd_data (tbl_data)
    );

    tsn_emit #(
        .TERM_MAX (TERM_MAX)
    ) u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (job_vld),
        .job_in      (job),
        .ready       (emit_ready),
        .tbl_data    (tbl_data),
        .wr          (wr),
        .term_text   (term_text_reg),
        .term_length (term_length_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

// File: hdl/tsn_checker.sv
// Port-level checks for the telnet stream negotiator, bound to the top level.
// Sees only the top-level ports; no package dependency.
module tsn_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);

    // Reset empties the result channel
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat visible after reset");

    // A stalled result beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result beat changed");

    // Bytes for the local user are always single-beat results
    a_local_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("local byte not marked last");

    // Every multi-beat result goes to the network
    a_multi_to_net: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser[0])
        else $error("non-last beat addressed to local user");

endmodule

bind telnet_stream_negotiator tsn_checker u_tsn_checker (.*);

// File: tb/testbench.sv
// Self-checking testbench for telnet_stream_negotiator: directed and random byte streams
// with an in-bench negotiation predictor and a result-beat scoreboard.
// Depends on hdl/tsn_pkg.sv and hdl/telnet_stream_negotiator.sv.
`timescale 1ns / 1ps

module testbench;

    typedef enum logic [2:0] {
        PHASE_DATA, PHASE_CODE, PHASE_OPTION, PHASE_SUBPAR, PHASE_SUBCODE
    } phase_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       to_network;
        logic       last;
    } reply_beat_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] data_byte
    logic [0:0]  s_tuser;     // [0] mode
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [7:0]  m_tdata;     // [7:0] out_byte
    logic [0:0]  m_tuser;     // [0] to_network
    logic        m_tlast;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [63:0] cfg_wdata;

    // Predictor state
    phase_t      parse_phase;
    logic [7:0]  pending_cmd;
    logic [7:0]  sub_opt;
    logic [1:0]  remote_state [256];
    logic [1:0]  local_state [256];
    logic [63:0] term_text;
    logic [3:0]  term_len;

    reply_beat_t expected_beats [$];
    reply_beat_t reply_burst [$];
    reply_beat_t head_beat;

    int unsigned errors;
    int unsigned beats_in;
    int unsigned beats_checked;
    int unsigned ttype_answers;
    int unsigned setting_writes;
    int unsigned stall_left = 0;
    bit          quiet_tail;

    telnet_stream_negotiator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Hard stop in case the block hangs
    initial begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void emit(input logic [7:0] value, input logic net);
        reply_beat_t beat;
        beat.out_byte   = value;
        beat.to_network = net;
        beat.last       = 1'b0;
        reply_burst     = {reply_burst, beat};
    endfunction

    function automatic void answer(input logic [7:0] cmd, input logic [7:0] opt);
        emit(tsn_pkg::B_IAC, 1'b1);
        emit(cmd, 1'b1);
        emit(opt, 1'b1);
    endfunction

    task automatic reset_negotiation();
        parse_phase = PHASE_DATA;
        pending_cmd = 8'd0;
        sub_opt     = 8'd0;
        for (int i = 0; i < 256; i++) begin
            remote_state[i] = tsn_pkg::ST_CANT;
            local_state[i]  = tsn_pkg::ST_CANT;
        end
        remote_state[tsn_pkg::OPT_ECHO] = tsn_pkg::ST_NO;
        local_state[tsn_pkg::OPT_TTYPE] = tsn_pkg::ST_NO;
        term_text = tsn_pkg::TERM_TEXT_RST;
        term_len  = tsn_pkg::TERM_LENGTH_RST;
    endtask

    // Advance the negotiation state by one byte and queue the beats it causes
    task automatic negotiate_byte(input logic mode, input logic [7:0] value);
        int unsigned n;
        reply_burst.delete();
        if (mode) begin
            if (value == tsn_pkg::B_IAC)
                emit(tsn_pkg::B_IAC, 1'b1);
            emit(value, 1'b1);
        end else begin
            case (parse_phase)
                PHASE_CODE: begin
                    if (value == tsn_pkg::B_IAC) begin
                        emit(tsn_pkg::B_IAC, 1'b0);
                        parse_phase = PHASE_DATA;
                    end else if (value inside {tsn_pkg::B_SB, tsn_pkg::B_WILL,
                                               tsn_pkg::B_WONT, tsn_pkg::B_DO,
                                               tsn_pkg::B_DONT}) begin
                        pending_cmd = value;
                        parse_phase = PHASE_OPTION;
                    end else begin
                        parse_phase = PHASE_DATA;
                    end
                end
                PHASE_OPTION: begin
                    parse_phase = PHASE_DATA;
                    case (pending_cmd)
                        tsn_pkg::B_SB: begin
                            sub_opt     = value;
                            parse_phase = PHASE_SUBPAR;
                        end
                        tsn_pkg::B_WILL: begin
                            if (remote_state[value] == tsn_pkg::ST_CANT) begin
                                answer(tsn_pkg::B_DONT, value);
                            end else if (remote_state[value] == tsn_pkg::ST_NO) begin
                                remote_state[value] = tsn_pkg::ST_YES;
                                answer(tsn_pkg::B_DO, value);
                            end
                        end
                        tsn_pkg::B_WONT: begin
                            if (remote_state[value] != tsn_pkg::ST_CANT &&
                                remote_state[value] != tsn_pkg::ST_NO) begin
                                remote_state[value] = tsn_pkg::ST_NO;
                                answer(tsn_pkg::B_DONT, value);
                            end
                        end
                        tsn_pkg::B_DO: begin
                            if (local_state[value] == tsn_pkg::ST_CANT) begin
                                answer(tsn_pkg::B_WONT, value);
                            end else if (local_state[value] == tsn_pkg::ST_NO) begin
                                local_state[value] = tsn_pkg::ST_YES;
                                answer(tsn_pkg::B_WILL, value);
                            end
                        end
                        tsn_pkg::B_DONT: begin
                            if (local_state[value] != tsn_pkg::ST_CANT &&
                                local_state[value] != tsn_pkg::ST_NO) begin
                                local_state[value] = tsn_pkg::ST_NO;
                                answer(tsn_pkg::B_WONT, value);
                            end
                        end
                        default: ;
                    endcase
                end
                PHASE_SUBPAR: begin
                    if (value == tsn_pkg::B_IAC)
                        parse_phase = PHASE_SUBCODE;
                end
                PHASE_SUBCODE: begin
                    if (value == tsn_pkg::B_IAC) begin
                        parse_phase = PHASE_SUBPAR;
                    end else begin
                        // Terminal type query: answer with the configured text
                        if (value == tsn_pkg::B_SE && sub_opt == tsn_pkg::OPT_TTYPE) begin
                            n = (term_len > tsn_pkg::TERM_MAX_DEF) ?
                                tsn_pkg::TERM_MAX_DEF : term_len;
                            answer(tsn_pkg::B_SB, sub_opt);
                            emit(8'd0, 1'b1);
                            for (int i = 0; i < n; i++)
                                emit(term_text[8*i +: 8], 1'b1);
                            emit(tsn_pkg::B_IAC, 1'b1);
                            emit(tsn_pkg::B_SE, 1'b1);
                            ttype_answers++;
                        end
                        parse_phase = PHASE_DATA;
                    end
                end
                default: begin
                    if (value == tsn_pkg::B_IAC)
                        parse_phase = PHASE_CODE;
                    else
                        emit(value, 1'b0);
                end
            endcase
        end
        if (reply_burst.size() > 0)
            reply_burst[reply_burst.size() - 1].last = 1'b1;
        expected_beats = {expected_beats, reply_burst};
    endtask

    // ---------------------------------------------------------------- result side

    // Stall the result channel in random bursts, never in the quiet tail
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 5);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_beats.size() == 0) begin
                $error("unexpected beat: out_byte %0d to_network %0d last %0d",
                       m_tdata, m_tuser[0], m_tlast);
                errors++;
            end else begin
                head_beat = expected_beats.pop_front();
                beats_checked++;
                if (m_tdata !== head_beat.out_byte) begin
                    $error("out_byte: expected %0d, got %0d", head_beat.out_byte, m_tdata);
                    errors++;
                end
                if (m_tuser[0] !== head_beat.to_network) begin
                    $error("to_network: expected %0d, got %0d",
                           head_beat.to_network, m_tuser[0]);
                    errors++;
                end
                if (m_tlast !== head_beat.last) begin
                    $error("last: expected %0d, got %0d", head_beat.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- input side

    // Present one byte, with an occasional idle burst ahead of it
    task automatic send_beat(input logic mode, input logic [7:0] value);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        negotiate_byte(mode, value);
        beats_in++;
    endtask

    task automatic send_command(input logic [7:0] cmd, input logic [7:0] opt);
        send_beat(1'b0, tsn_pkg::B_IAC);
        send_beat(1'b0, cmd);
        send_beat(1'b0, opt);
    endtask

    // IAC SB opt <params, IAC escaped> IAC SE
    task automatic send_subneg(input logic [7:0] opt, input int unsigned nparams);
        logic [7:0] param;
        send_beat(1'b0, tsn_pkg::B_IAC);
        send_beat(1'b0, tsn_pkg::B_SB);
        send_beat(1'b0, opt);
        repeat (nparams) begin
            param = ($urandom_range(0, 5) == 0) ? tsn_pkg::B_IAC : 8'($urandom_range(0, 255));
            send_beat(1'b0, param);
            if (param == tsn_pkg::B_IAC)
                send_beat(1'b0, tsn_pkg::B_IAC);
        end
        send_beat(1'b0, tsn_pkg::B_IAC);
        send_beat(1'b0, tsn_pkg::B_SE);
    endtask

    // Hold the input until every expected beat is out and the pipeline is empty
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic set_terminal(input logic [63:0] text, input logic [3:0] len);
        cfg_we    <= 1'b1;
        cfg_index <= tsn_pkg::REG_TERM_TEXT;
        cfg_wdata <= text;
        @(posedge aclk);
        cfg_index <= tsn_pkg::REG_TERM_LENGTH;
        cfg_wdata <= {60'd0, len};
        term_text = text;
        @(posedge aclk);
        cfg_we   <= 1'b0;
        term_len = len;
        setting_writes += 2;
    endtask

    function automatic logic [7:0] pick_option();
        case ($urandom_range(0, 4))
            0:       return tsn_pkg::OPT_ECHO;
            1:       return tsn_pkg::OPT_TTYPE;
            2:       return 8'($urandom_range(0, 7));
            3:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_local_path();
        send_beat(1'b1, 8'h00);
        send_beat(1'b1, tsn_pkg::B_IAC);
    endtask

    task automatic test_network_data();
        send_beat(1'b0, 8'h00);
        send_beat(1'b0, tsn_pkg::B_IAC);
        send_beat(1'b0, tsn_pkg::B_IAC);
        // Unknown code after IAC drops back to data
        send_beat(1'b0, tsn_pkg::B_IAC);
        send_beat(1'b0, 8'd241);
    endtask

    task automatic test_option_replies();
        send_command(tsn_pkg::B_WILL, tsn_pkg::OPT_ECHO);
        send_command(tsn_pkg::B_WONT, tsn_pkg::OPT_ECHO);
        send_command(tsn_pkg::B_DO, tsn_pkg::OPT_TTYPE);
        send_command(tsn_pkg::B_DONT, tsn_pkg::OPT_TTYPE);
        send_command(tsn_pkg::B_WILL, 8'd255);
        send_command(tsn_pkg::B_DO, 8'd255);
    endtask

    task automatic test_subnegotiation();
        send_subneg(tsn_pkg::OPT_TTYPE, 1);
        // SE closing another option is ignored
        send_subneg(8'd5, 0);
        // Unknown code inside a subnegotiation aborts it
        send_beat(1'b0, tsn_pkg::B_IAC);
        send_beat(1'b0, tsn_pkg::B_SB);
        send_beat(1'b0, tsn_pkg::OPT_TTYPE);
        send_beat(1'b0, tsn_pkg::B_IAC);
        send_beat(1'b0, 8'd7);
    endtask

    task automatic test_term_settings();
        drain();
        set_terminal(tsn_pkg::TERM_TEXT_RST, 4'd0);
        send_subneg(tsn_pkg::OPT_TTYPE, 0);
        drain();
        // Text bytes of 255 go out as they are
        set_terminal({64{1'b1}}, 4'd8);
        send_subneg(tsn_pkg::OPT_TTYPE, 0);
        drain();
        // Lengths past the maximum saturate
        set_terminal(64'd0, 4'd15);
        send_subneg(tsn_pkg::OPT_TTYPE, 0);
        drain();
        set_terminal({$urandom(), $urandom()}, 4'($urandom_range(1, 7)));
        send_subneg(tsn_pkg::OPT_TTYPE, 0);
    endtask

    task automatic run_random_traffic(input int unsigned count);
        int unsigned start_count;
        int unsigned pick;
        logic [7:0]  cmd;
        start_count = beats_in;
        while (beats_in - start_count < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 22) begin
                send_beat(1'b1, ($urandom_range(0, 7) == 0) ? tsn_pkg::B_IAC
                                                             : 8'($urandom_range(0, 255)));
            end else if (pick < 38) begin
                send_beat(1'b0, 8'($urandom_range(0, 254)));
            end else if (pick < 43) begin
                send_beat(1'b0, tsn_pkg::B_IAC);
                send_beat(1'b0, tsn_pkg::B_IAC);
            end else if (pick < 72) begin
                case ($urandom_range(0, 3))
                    0:       cmd = tsn_pkg::B_WILL;
                    1:       cmd = tsn_pkg::B_WONT;
                    2:       cmd = tsn_pkg::B_DO;
                    default: cmd = tsn_pkg::B_DONT;
                endcase
                send_command(cmd, pick_option());
            end else if (pick < 88) begin
                send_subneg(($urandom_range(0, 9) < 7) ? tsn_pkg::OPT_TTYPE
                                                       : 8'($urandom_range(0, 255)),
                            $urandom_range(0, 4));
            end else if (pick < 94) begin
                // Subnegotiation broken off by an unknown code
                send_beat(1'b0, tsn_pkg::B_IAC);
                send_beat(1'b0, tsn_pkg::B_SB);
                send_beat(1'b0, pick_option());
                send_beat(1'b0, 8'($urandom_range(0, 255)));
                send_beat(1'b0, tsn_pkg::B_IAC);
                send_beat(1'b0, 8'($urandom_range(0, 239)));
            end else begin
                // Noise: IAC followed by any byte
                send_beat(1'b0, tsn_pkg::B_IAC);
                send_beat(1'b0, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'd0;
        s_tuser   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= tsn_pkg::REG_TERM_TEXT;
        cfg_wdata <= 64'd0;
        errors         = 0;
        beats_in       = 0;
        beats_checked  = 0;
        ttype_answers  = 0;
        setting_writes = 0;
        quiet_tail     = 1'b0;
        reset_negotiation();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_local_path();
        test_network_data();
        test_option_replies();
        test_subnegotiation();
        test_term_settings();

        run_random_traffic(60);
        drain();
        set_terminal({$urandom(), $urandom()}, 4'($urandom_range(0, 15)));

        // Last stretch runs without any idling on either side
        quiet_tail = 1'b1;
        run_random_traffic(50);
        drain();

        $display("Covered %0d input beats and %0d result beats, %0d terminal type answers,",
                 beats_in, beats_checked, ttype_answers);
        $display("%0d register writes, option replies in both directions and stalls.",
                 setting_writes);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/tsn_pkg.sv
hdl/tsn_opt_mem.sv
hdl/tsn_parse.sv
hdl/tsn_emit.sv
hdl/telnet_stream_negotiator.sv
hdl/tsn_checker.sv
tb/testbench.sv
